// File: hw/rtl/nnzc_pkg.sv
// shared constants, payload types and address helper for the zoom crop block
package nnzc_pkg;

  localparam int unsigned MAX_WIDTH   = 256;
  localparam int unsigned MAX_HEIGHT  = 256;
  localparam int unsigned MAX_SCALE   = 16;
  localparam int unsigned DIM_MAX     = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

  localparam int unsigned CRD_W   = 8;
  localparam int unsigned SIZE_W  = 9;
  localparam int unsigned PIV_W   = 8;
  localparam int unsigned SCALE_W = 5;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned PIX_W   = 3 * CH_W;
  localparam int unsigned CFG_W   = SIZE_W;
  localparam int unsigned IDX_W   = 3;

  localparam int unsigned DIV_W        = $clog2(DIM_MAX * MAX_SCALE);
  localparam int unsigned DCNT_W       = $clog2(DIV_W + 1);
  localparam int unsigned RESULT_DELAY = DIV_W + 4;

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_PIVOT_X      = 3'd2,
    REG_PIVOT_Y      = 3'd3,
    REG_ZOOM_SCALE   = 3'd4
  } nnzc_reg_e;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } nnzc_req_e;

  typedef struct packed {
    logic             req_type;
    logic [CRD_W-1:0] pix_x;
    logic [CRD_W-1:0] pix_y;
    logic [CH_W-1:0]  in_red;
    logic [CH_W-1:0]  in_green;
    logic [CH_W-1:0]  in_blue;
  } nnzc_req_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
  } nnzc_res_t;

  function automatic logic [ADDR_W-1:0] pix_addr(logic [SIZE_W-1:0] row,
                                                 logic [SIZE_W-1:0] col);
    pix_addr = ADDR_W'(row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
  endfunction

endpackage

// File: hw/rtl/nnzc_ram.sv
// generic single port ram with registered read
module nnzc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/nnzc_div.sv
// iterative restoring divider, one quotient bit per cycle
module nnzc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [nnzc_pkg::DIV_W-1:0]    dividend_i,
  input  logic [nnzc_pkg::SCALE_W-1:0]  divisor_i,
  output logic [nnzc_pkg::DIV_W-1:0]    quotient_o,
  output logic                          done_o
);
  import nnzc_pkg::*;

  logic [DCNT_W-1:0]  cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [DIV_W-1:0]   quo_q, quo_d;
  logic [SCALE_W-1:0] rem_q, rem_d;
  logic [SCALE_W-1:0] dvs_q, dvs_d;
  logic [SCALE_W:0]   shift;

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    shift  = {rem_q, quo_q[DIV_W-1]};
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = DCNT_W'(DIV_W);
    end else if (cnt_q != '0) begin
      if (shift >= {1'b0, dvs_q}) begin
        rem_d = SCALE_W'(shift - {1'b0, dvs_q});
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = shift[SCALE_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - DCNT_W'(1);
      done_d = (cnt_q == DCNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// File: hw/rtl/nearest_neighbor_zoom_crop_top.sv
// top level of the nearest neighbor zoom crop block
//
// command channel: a transaction is taken when start is high and busy is low.
// a write transaction (req_type 0) stores one source pixel in the frame store
// in the cycle it is taken; writes outside the configured frame are dropped.
// writes never raise busy, so one write per cycle is sustained while no read is busy.
// a read transaction (req_type 1) maps the view coordinate to a source pixel
// through the clamped crop offset and a division by the zoom scale.
// result_valid_o pulses for one cycle with res_o once the read has passed the
// offset, divide and fetch states; busy is high until then and the next
// transaction can be taken in the strobe cycle, so a new read waits for the strobe.
// the read time is set by the 12-step iterative divider (one per axis, both
// in parallel) plus offset, frame store read and output register stages.
// the result is not held: the receiver takes it in the strobe cycle.
// configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i), to be
// written only while the block is idle, which the block does not enforce; reset
// loads a 256 x 256 frame, pivot 0, scale 1, leaves frame store contents undefined.
module nearest_neighbor_zoom_crop_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  nnzc_pkg::nnzc_req_t        req_i,
  output logic                       result_valid_o,
  output nnzc_pkg::nnzc_res_t        res_o,
  input  logic                       cfg_we_i,
  input  logic [nnzc_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [nnzc_pkg::CFG_W-1:0] cfg_wdata_i
);
  import nnzc_pkg::*;

  localparam int unsigned ARITH_W = SIZE_W + SCALE_W + 1;
  localparam int unsigned CMP_W   = (DIV_W > SIZE_W) ? DIV_W : SIZE_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OFFS,
    ST_DIV,
    ST_FETCH
  } state_e;

  state_e              state_q;
  logic [SIZE_W-1:0]   width_q, height_q;
  logic [PIV_W-1:0]    pivx_q, pivy_q;
  logic [SCALE_W-1:0]  scale_q;
  logic [CRD_W-1:0]    crd_x_q, crd_y_q;
  logic [ARITH_W-1:0]  prod_x_q, prod_y_q, top_x_q, top_y_q;
  logic                valid_q;
  nnzc_res_t           res_q;

  logic [SIZE_W-1:0]   w_eff, h_eff;
  logic [SCALE_W-1:0]  s_eff;
  logic                accept, wr_en, div_start, done_x, done_y;
  logic [DIV_W-1:0]    dvd_x, dvd_y, quo_x, quo_y;
  logic [SIZE_W-1:0]   src_x, src_y;
  logic [ADDR_W-1:0]   ram_addr;
  logic [PIX_W-1:0]    ram_rdata;

  function automatic logic [DIV_W-1:0] axis_dividend(logic [ARITH_W-1:0] prod,
                                                     logic [ARITH_W-1:0] top,
                                                     logic [SIZE_W-1:0]  size,
                                                     logic [CRD_W-1:0]   crd);
    logic signed [ARITH_W-1:0] off;
    logic [ARITH_W-1:0]        offc;
    logic [SIZE_W-1:0]         c;
    off = $signed(prod) - $signed(ARITH_W'(size >> 1));
    if (off < 0) begin
      offc = '0;
    end else if ($unsigned(off) > top) begin
      offc = top;
    end else begin
      offc = $unsigned(off);
    end
    c = (SIZE_W'(crd) >= size) ? size - SIZE_W'(1) : SIZE_W'(crd);
    return DIV_W'(offc + ARITH_W'(c));
  endfunction

  function automatic logic [SIZE_W-1:0] axis_clamp(logic [DIV_W-1:0]  quo,
                                                   logic [SIZE_W-1:0] size);
    if (CMP_W'(quo) >= CMP_W'(size)) begin
      return size - SIZE_W'(1);
    end
    return SIZE_W'(quo);
  endfunction

  // effective settings, out of range values saturate
  always_comb begin
    if (width_q == '0) begin
      w_eff = SIZE_W'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = SIZE_W'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
    if (scale_q == '0) begin
      s_eff = SCALE_W'(1);
    end else if (32'(scale_q) > MAX_SCALE) begin
      s_eff = SCALE_W'(MAX_SCALE);
    end else begin
      s_eff = scale_q;
    end
  end

  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign wr_en     = accept && (req_i.req_type == REQ_WRITE) &&
                     (SIZE_W'(req_i.pix_x) < w_eff) && (SIZE_W'(req_i.pix_y) < h_eff);
  assign div_start = (state_q == ST_OFFS);
  assign dvd_x     = axis_dividend(prod_x_q, top_x_q, w_eff, crd_x_q);
  assign dvd_y     = axis_dividend(prod_y_q, top_y_q, h_eff, crd_y_q);
  assign src_x     = axis_clamp(quo_x, w_eff);
  assign src_y     = axis_clamp(quo_y, h_eff);
  assign ram_addr  = wr_en ? pix_addr(SIZE_W'(req_i.pix_y), SIZE_W'(req_i.pix_x))
                           : pix_addr(src_y, src_x);

  nnzc_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_x),
    .divisor_i  (s_eff),
    .quotient_o (quo_x),
    .done_o     (done_x)
  );

  nnzc_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_y),
    .divisor_i  (s_eff),
    .quotient_o (quo_y),
    .done_o     (done_y)
  );

  nnzc_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .addr_i  (ram_addr),
    .wdata_i ({req_i.in_red, req_i.in_green, req_i.in_blue}),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      valid_q  <= 1'b0;
      width_q  <= SIZE_W'(256);
      height_q <= SIZE_W'(256);
      pivx_q   <= '0;
      pivy_q   <= '0;
      scale_q  <= SCALE_W'(1);
      crd_x_q  <= '0;
      crd_y_q  <= '0;
      prod_x_q <= '0;
      prod_y_q <= '0;
      top_x_q  <= '0;
      top_y_q  <= '0;
      res_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_FRAME_WIDTH:  width_q  <= cfg_wdata_i[SIZE_W-1:0];
          REG_FRAME_HEIGHT: height_q <= cfg_wdata_i[SIZE_W-1:0];
          REG_PIVOT_X:      pivx_q   <= cfg_wdata_i[PIV_W-1:0];
          REG_PIVOT_Y:      pivy_q   <= cfg_wdata_i[PIV_W-1:0];
          REG_ZOOM_SCALE:   scale_q  <= cfg_wdata_i[SCALE_W-1:0];
          default: ;
        endcase
      end
      valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept && (req_i.req_type == REQ_READ)) begin
            crd_x_q  <= req_i.pix_x;
            crd_y_q  <= req_i.pix_y;
            prod_x_q <= ARITH_W'(pivx_q) * ARITH_W'(s_eff);
            prod_y_q <= ARITH_W'(pivy_q) * ARITH_W'(s_eff);
            top_x_q  <= ARITH_W'(w_eff) * ARITH_W'(s_eff - SCALE_W'(1));
            top_y_q  <= ARITH_W'(h_eff) * ARITH_W'(s_eff - SCALE_W'(1));
            state_q  <= ST_OFFS;
          end
        end
        ST_OFFS: state_q <= ST_DIV;
        ST_DIV: begin
          if (done_x && done_y) begin
            state_q <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          res_q   <= nnzc_res_t'(ram_rdata);
          valid_q <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_valid_o = valid_q;
  assign res_o          = res_q;

endmodule

// File: hw/rtl/nnzc_checker.sv
// port level checks of the zoom crop top level and their bind
module nnzc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input nnzc_pkg::nnzc_req_t req_i,
  input logic                result_valid_o
);
  import nnzc_pkg::*;

  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.req_type == REQ_READ) |-> ##RESULT_DELAY result_valid_o)
    else $error("read transaction without result at the expected cycle");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.req_type == REQ_WRITE) |=> (!busy && !result_valid_o))
    else $error("write transaction raised busy or produced a result");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_strobe_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (!busy && $past(busy)))
    else $error("result strobe not at the end of a busy period");

endmodule

bind nearest_neighbor_zoom_crop_top nnzc_checker u_nnzc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .req_i          (req_i),
  .result_valid_o (result_valid_o)
);
